>>> rtl/ppds_pkg.sv
// Package for the point pair distance statistics unit.
// Holds the field widths, the beat structs, the chain control struct and the state encoding.
// Depends on nothing.
package ppds_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIST_W     = 26;
  localparam int SQOUT_W    = 50;
  localparam int COUNT_W    = 11;
  localparam int SQ_W       = 2 * COORD_BITS + 2;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int WIDE_W     = 64;
  localparam int ROOT_W     = 32;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic                         last_pair;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [SQOUT_W-1:0] squared_distance;
    logic               stats_valid;
    logic [DIST_W-1:0]  mean_distance;
    logic [SQOUT_W-1:0] variance;
    logic [DIST_W-1:0]  std_dev;
    logic [DIST_W-1:0]  rms_distance;
    logic [DIST_W-1:0]  min_distance;
    logic [DIST_W-1:0]  max_distance;
    logic [DIST_W-1:0]  median_distance;
    logic [COUNT_W-1:0] pair_count;
    logic               status;
  } result_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_INSERT,
    ST_DIV_MEAN,
    ST_DIV_MSQ,
    ST_DRAIN,
    ST_DIV_VAR,
    ST_ROOT_VAR,
    ST_ROOT_RMS
  } state_t;

endpackage

>>> rtl/ppds_cell.sv
// One cell of the sorting chain: holds one distance and an occupied flag.
// Inserts in ascending order or shifts toward cell zero. Depends on ppds_pkg.
module ppds_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  ppds_pkg::chain_ctrl_t       ctrl,
  input  logic [ppds_pkg::DIST_W-1:0] ins_val,
  input  logic [ppds_pkg::DIST_W-1:0] prev_val,
  input  logic                        prev_occ,
  input  logic                        prev_le,
  input  logic [ppds_pkg::DIST_W-1:0] next_val,
  input  logic                        next_occ,
  output logic [ppds_pkg::DIST_W-1:0] val,
  output logic                        occ,
  output logic                        le
);
  import ppds_pkg::*;

  assign le = occ && (val <= ins_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= next_occ;
    end else if (ctrl.insert && !le) begin
      occ <= prev_le ? 1'b1 : prev_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= next_val;
    end else if (ctrl.insert && !le) begin
      val <= prev_le ? ins_val : prev_val;
    end
  end

endmodule

>>> rtl/ppds_isqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on ppds_pkg.
module ppds_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ppds_pkg::WIDE_W-1:0] operand,
  output logic                        done,
  output logic [ppds_pkg::ROOT_W-1:0] root
);
  import ppds_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [WIDE_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [5:0]        cnt;
  logic              run;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign rem_sh = {rem, rad[WIDE_W-1:WIDE_W-2]};
  assign trial  = {(REM_W)'(root), 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && (cnt == 6'(ROOT_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ROOT_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad <= {rad[WIDE_W-3:0], 2'b00};
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/ppds_div.sv
// Restoring divider for a 64-bit numerator and a narrow denominator, one quotient bit per cycle.
// Depends on ppds_pkg.
module ppds_div #(
  parameter int DEN_W = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ppds_pkg::WIDE_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  output logic                        done,
  output logic [ppds_pkg::WIDE_W-1:0] quo
);
  import ppds_pkg::*;

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [6:0]       cnt;
  logic             run;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[WIDE_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && !start && (cnt == 7'(WIDE_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(WIDE_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_r <= den;
      rem   <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, den_r});
        quo <= {quo[WIDE_W-2:0], 1'b1};
      end else begin
        rem <= DEN_W'(rem_sh);
        quo <= {quo[WIDE_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/point_pair_distance_statistics_unit.sv
// Top level of the point pair distance statistics unit.
// Uses ppds_pkg, ppds_cell, ppds_isqrt and ppds_div.
//
// Usage. A pair beat is taken at a rising edge where start is high and busy
// is low. Each beat gives exactly one result beat, shown on result for one
// cycle while done is high; the receiver cannot stall it and must take it.
// A pair's distance comes from three squared axis differences on one shared
// multiplier and a one-bit-per-cycle square root, then it is inserted into
// the sorting chain, one pair at a time. For a pair marked last, the unit
// then divides the sums by the count, drains the sorted chain through cell
// zero to collect minimum, maximum, median and the squared deviations,
// divides once more and takes two roots.
// Sums, count and overflow status are then cleared for the next set.
// Synchronous reset empties the chain and clears all sums; no pass is needed.
// Pairs beyond MAX_PAIRS get their own distance but are not kept, and the
// set's status reads 1.
module point_pair_distance_statistics_unit #(
  parameter int MAX_PAIRS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ppds_pkg::pair_t   pair,
  output logic              done,
  output ppds_pkg::result_t result
);
  import ppds_pkg::*;

  localparam int N_W    = $clog2(MAX_PAIRS + 1);
  localparam int CNT_W  = $clog2(MAX_PAIRS + 3);
  localparam int DSUM_W = DIST_W + N_W;
  localparam int DEV2_W = 2 * DIST_W;
  localparam logic [WIDE_W-1:0] DIST_MAX  = WIDE_W'((64'd1 << DIST_W) - 64'd1);
  localparam logic [WIDE_W-1:0] SQOUT_MAX = WIDE_W'((64'd1 << SQOUT_W) - 64'd1);
  localparam logic [WIDE_W-1:0] COUNT_MAX = WIDE_W'((64'd1 << COUNT_W) - 64'd1);

  state_t state, state_next;

  // Per-pair datapath.
  logic [COORD_BITS-1:0] abs_x, abs_y, abs_z;
  logic [COORD_BITS-1:0] ax, ay, az, mul_a;
  logic                  last;
  logic [2:0]            sq_step;
  logic [PROD_W-1:0]     prod_r;
  logic [SQ_W-1:0]       sq;
  logic [DIST_W-1:0]     pair_dist;

  // Set accumulators.
  logic [DSUM_W-1:0] distance_sum, distance_sum_next;
  logic [WIDE_W-1:0] squared_sum, squared_sum_next;
  logic [N_W-1:0]    pairs_seen, pairs_seen_next;
  logic              overflow_flag, overflow_flag_next;
  logic              room;
  logic [WIDE_W:0]   ssum_add;

  // Finishing pass.
  logic [DIST_W-1:0] mean;
  logic [WIDE_W-1:0] msq;
  logic [WIDE_W-1:0] var_q;
  logic [DIST_W-1:0] std_r;
  logic [CNT_W-1:0]  k, n_ext, lo_idx, hi_idx, max_idx;
  logic [DIST_W-1:0] min_r, max_r, lo_r, hi_r;
  logic [DIST_W-1:0] dev_r, d0;
  logic [DEV2_W-1:0] dev2_r;
  logic              va, vb;
  logic [WIDE_W-1:0] acc;
  logic [WIDE_W:0]   acc_add;
  logic [DIST_W:0]   med_sum;
  result_t           pair_res, stats_res;

  // Shared units.
  logic              root_start, root_done;
  logic [WIDE_W-1:0] root_operand;
  logic [ROOT_W-1:0] root;
  logic [DIST_W-1:0] root_sat;
  logic              div_start, div_done;
  logic [WIDE_W-1:0] div_num, div_quo;
  logic [N_W-1:0]    div_den;
  logic [WIDE_W-1:0] sq_ext;

  chain_ctrl_t       ctrl;
  logic [DIST_W-1:0] cell_val [MAX_PAIRS];
  logic              cell_occ [MAX_PAIRS];
  logic              cell_le  [MAX_PAIRS];

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] m;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    m = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
    return m[COORD_BITS-1:0];
  endfunction

  assign abs_x = abs_diff(pair.first_x, pair.second_x);
  assign abs_y = abs_diff(pair.first_y, pair.second_y);
  assign abs_z = abs_diff(pair.first_z, pair.second_z);

  always_comb begin
    case (sq_step)
      3'd0:    mul_a = ax;
      3'd1:    mul_a = ay;
      default: mul_a = az;
    endcase
  end

  // A pair is kept only while the chain has a free cell.
  assign room               = pairs_seen < N_W'(MAX_PAIRS);
  assign ssum_add           = {1'b0, squared_sum} + (WIDE_W+1)'(sq);
  assign distance_sum_next  = room ? distance_sum + DSUM_W'(pair_dist) : distance_sum;
  assign squared_sum_next   = !room ? squared_sum :
                              (ssum_add[WIDE_W] ? '1 : ssum_add[WIDE_W-1:0]);
  assign pairs_seen_next    = room ? pairs_seen + N_W'(1) : pairs_seen;
  assign overflow_flag_next = overflow_flag | !room;

  assign root_sat = (WIDE_W'(root) > DIST_MAX) ? '1 : DIST_W'(root);
  assign sq_ext   = WIDE_W'(sq);

  // Indexes into the sorted order for max and the two middle elements.
  assign n_ext   = CNT_W'(pairs_seen);
  assign max_idx = n_ext - CNT_W'(1);
  assign lo_idx  = max_idx >> 1;
  assign hi_idx  = n_ext >> 1;
  assign d0      = cell_val[0];
  assign acc_add = {1'b0, acc} + (WIDE_W+1)'(dev2_r);
  assign med_sum = {1'b0, lo_r} + {1'b0, hi_r};

  // Result beats: the per-pair fields alone, or the same beat with the set
  // statistics filled in.
  always_comb begin
    pair_res                  = '0;
    pair_res.distance         = pair_dist;
    pair_res.squared_distance = (sq_ext > SQOUT_MAX) ? '1 : SQOUT_W'(sq_ext);
    stats_res                 = result;
    stats_res.stats_valid     = 1'b1;
    stats_res.mean_distance   = mean;
    stats_res.variance        = (var_q > SQOUT_MAX) ? '1 : SQOUT_W'(var_q);
    stats_res.std_dev         = std_r;
    stats_res.rms_distance    = root_sat;
    stats_res.min_distance    = min_r;
    stats_res.max_distance    = max_r;
    stats_res.median_distance = med_sum[DIST_W:1];
    stats_res.pair_count      = (WIDE_W'(pairs_seen) > COUNT_MAX) ? '1 : COUNT_W'(pairs_seen);
    stats_res.status          = overflow_flag;
  end

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    root_start   = 1'b0;
    root_operand = sq_ext;
    div_start    = 1'b0;
    div_num      = squared_sum;
    div_den      = pairs_seen;
    ctrl         = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (sq_step == 3'd4) begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        ctrl.insert = room;
        if (last) begin
          // The sums are taken as they stand after this pair.
          div_start  = 1'b1;
          div_num    = WIDE_W'(distance_sum_next);
          div_den    = pairs_seen_next;
          state_next = ST_DIV_MEAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_MSQ;
        end
      end
      ST_DIV_MSQ: begin
        if (div_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        ctrl.shift = k < n_ext;
        if (k == n_ext + CNT_W'(2)) begin
          div_start  = 1'b1;
          div_num    = acc;
          state_next = ST_DIV_VAR;
        end
      end
      ST_DIV_VAR: begin
        if (div_done) begin
          root_start   = 1'b1;
          root_operand = div_quo;
          state_next   = ST_ROOT_VAR;
        end
      end
      ST_ROOT_VAR: begin
        if (root_done) begin
          root_start   = 1'b1;
          root_operand = msq;
          state_next   = ST_ROOT_RMS;
        end
      end
      ST_ROOT_RMS: begin
        if (root_done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: accumulators, counters, drain valid bits and the strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum  <= '0;
      squared_sum   <= '0;
      pairs_seen    <= '0;
      overflow_flag <= 1'b0;
      sq_step       <= '0;
      k             <= '0;
      va            <= 1'b0;
      vb            <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= ((state == ST_INSERT) && !last) || ((state == ST_ROOT_RMS) && root_done);
      va   <= (state == ST_DRAIN) && (k < n_ext);
      vb   <= va;
      if (state == ST_IDLE) sq_step <= '0;
      else if (state == ST_SQUARE) sq_step <= sq_step + 3'd1;
      if (state == ST_DIV_MSQ) k <= '0;
      else if (state == ST_DRAIN) k <= k + CNT_W'(1);
      if (state == ST_INSERT) begin
        distance_sum  <= distance_sum_next;
        squared_sum   <= squared_sum_next;
        pairs_seen    <= pairs_seen_next;
        overflow_flag <= overflow_flag_next;
      end
      if (state == ST_ROOT_RMS && root_done) begin
        distance_sum  <= '0;
        squared_sum   <= '0;
        pairs_seen    <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      ax   <= abs_x;
      ay   <= abs_y;
      az   <= abs_z;
      last <= pair.last_pair;
      sq   <= '0;
    end
    if (state == ST_SQUARE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_a);
      if (sq_step != 3'd0 && sq_step != 3'd4) sq <= sq + SQ_W'(prod_r);
    end
    if (state == ST_ROOT && root_done) pair_dist <= root_sat;
    if (state == ST_INSERT) result <= pair_res;
    if (state == ST_DIV_MEAN && div_done) mean <= DIST_W'(div_quo);
    if (state == ST_DIV_MSQ && div_done) begin
      msq <= div_quo;
      acc <= '0;
    end
    if (state == ST_DRAIN) begin
      // Cell zero presents the set in ascending order, one value a cycle.
      if (k < n_ext) begin
        dev_r <= (d0 >= mean) ? d0 - mean : mean - d0;
        if (k == '0) min_r <= d0;
        if (k == max_idx) max_r <= d0;
        if (k == lo_idx) lo_r <= d0;
        if (k == hi_idx) hi_r <= d0;
      end
      dev2_r <= DEV2_W'(dev_r) * DEV2_W'(dev_r);
      if (vb) acc <= acc_add[WIDE_W] ? '1 : acc_add[WIDE_W-1:0];
    end
    if (state == ST_DIV_VAR && div_done) var_q <= div_quo;
    if (state == ST_ROOT_VAR && root_done) std_r <= root_sat;
    if (state == ST_ROOT_RMS && root_done) result <= stats_res;
  end

  ppds_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (root_operand),
    .done    (root_done),
    .root    (root)
  );

  ppds_div #(
    .DEN_W (N_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // The sorting chain: cell zero holds the smallest value.
  for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
    logic [DIST_W-1:0] p_val, n_val;
    logic              p_occ, p_le, n_occ;
    if (i == 0) begin : g_head
      assign p_val = '0;
      assign p_occ = 1'b0;
      assign p_le  = 1'b1;
    end else begin : g_body
      assign p_val = cell_val[i-1];
      assign p_occ = cell_occ[i-1];
      assign p_le  = cell_le[i-1];
    end
    if (i == MAX_PAIRS - 1) begin : g_tail
      assign n_val = '0;
      assign n_occ = 1'b0;
    end else begin : g_link
      assign n_val = cell_val[i+1];
      assign n_occ = cell_occ[i+1];
    end
    ppds_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .ins_val  (pair_dist),
      .prev_val (p_val),
      .prev_occ (p_occ),
      .prev_le  (p_le),
      .next_val (n_val),
      .next_occ (n_occ),
      .val      (cell_val[i]),
      .occ      (cell_occ[i]),
      .le       (cell_le[i])
    );
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a pair is in flight");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted pair did not raise busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pairs_seen <= N_W'(MAX_PAIRS))
    else $error("pair count beyond chain length");
  a_stats_clear: assert property (@(posedge clk) disable iff (rst)
    (done && result.stats_valid) |-> (pairs_seen == '0 && !overflow_flag))
    else $error("set accumulators not cleared after statistics");
`endif

endmodule
